// ----- src/dbrf_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the double-buffered rectangle fill engine.
// No dependencies; used by src/double_buffered_rect_fill_engine.sv.
package dbrf_pkg;

	// Default store geometry (pixels per row, rows)
	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;

	// Width of the geometry registers
	localparam int CFG_W = 9;
	// Signed working width for clipping (16-bit coordinates plus sum headroom)
	localparam int GEO_W = 18;

	// Command codes
	typedef enum logic [2:0] {
		ACT_CLEAR = 3'd0,
		ACT_PUT   = 3'd1,
		ACT_FILL  = 3'd2,
		ACT_FLIP  = 3'd3,
		ACT_READ  = 3'd4
	} action_t;

	// Register indexes on the configuration port
	typedef enum logic [1:0] {
		REG_ENABLE = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2,
		REG_STRIDE = 2'd3
	} reg_idx_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SETUP,
		ST_MUL,
		ST_WALK,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// Command beat
	typedef struct packed {
		logic [2:0]         action;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] rect_w;
		logic signed [15:0] rect_h;
		logic [31:0]        color;
	} cmd_t;

	// Response beat
	typedef struct packed {
		logic [31:0] front_pixel;
		logic        drew;
		logic [31:0] draw_total;
		logic [31:0] flip_total;
	} rsp_t;

endpackage

// ----- src/double_buffered_rect_fill_engine.sv -----
`timescale 1ns / 1ps
// Double-buffered rectangle fill engine: back and front pixel stores, clip unit,
// pixel walker and configuration registers. Depends on src/dbrf_pkg.sv.

// After reset the engine sweeps both stores to zero, one word per cycle, over all
// MAX_WIDTH * MAX_HEIGHT words; no command is taken during that sweep, while
// register writes are. Every command then yields one response beat. A command
// holds the command channel through clip, row-base multiply, walk, drain and
// response load, and skips the multiply and walk when it touches no pixel: the
// walker issues one store access per cycle through the single write port of
// each store. A new command is taken while the previous response still waits
// downstream.
module double_buffered_rect_fill_engine #(
	parameter int MAX_WIDTH  = dbrf_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = dbrf_pkg::MAX_HEIGHT_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	// command channel
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  dbrf_pkg::cmd_t cmd,
	// response channel
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output dbrf_pkg::rsp_t rsp,
	// configuration port
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [3:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(MAX_WIDTH + 1);
	localparam int RW    = $clog2(MAX_HEIGHT + 1);
	localparam int GW    = dbrf_pkg::GEO_W;
	localparam int CFGW  = dbrf_pkg::CFG_W;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic            enable_q;
	logic [CFGW-1:0] width_q;
	logic [CFGW-1:0] height_q;
	logic [CFGW-1:0] stride_q;
	logic            cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	// Write a register on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			width_q  <= CFGW'(256);
			height_q <= CFGW'(256);
			stride_q <= CFGW'(256);
		end else if (cfg_wr) begin
			unique case (dbrf_pkg::reg_idx_t'(paddr[3:2]))
				dbrf_pkg::REG_ENABLE: enable_q <= pwdata[0];
				dbrf_pkg::REG_WIDTH:  width_q  <= pwdata[CFGW-1:0];
				dbrf_pkg::REG_HEIGHT: height_q <= pwdata[CFGW-1:0];
				dbrf_pkg::REG_STRIDE: stride_q <= pwdata[CFGW-1:0];
			endcase
		end
	end

	// Read back a register
	always_comb begin
		unique case (dbrf_pkg::reg_idx_t'(paddr[3:2]))
			dbrf_pkg::REG_ENABLE: prdata = {31'd0, enable_q};
			dbrf_pkg::REG_WIDTH:  prdata = {{(32-CFGW){1'b0}}, width_q};
			dbrf_pkg::REG_HEIGHT: prdata = {{(32-CFGW){1'b0}}, height_q};
			dbrf_pkg::REG_STRIDE: prdata = {{(32-CFGW){1'b0}}, stride_q};
		endcase
	end

	// Saturate geometry to the store size
	logic [CW-1:0] w_sat;
	logic [RW-1:0] h_sat;
	logic [CW-1:0] s_sat;

	always_comb begin
		w_sat = ({{(32-CFGW){1'b0}}, width_q} > 32'(MAX_WIDTH))
			? CW'(MAX_WIDTH) : CW'(width_q);
		h_sat = ({{(32-CFGW){1'b0}}, height_q} > 32'(MAX_HEIGHT))
			? RW'(MAX_HEIGHT) : RW'(height_q);
		s_sat = ({{(32-CFGW){1'b0}}, stride_q} > 32'(MAX_WIDTH))
			? CW'(MAX_WIDTH) : CW'(stride_q);
	end

	// ------------------------------------------------------------------
	// Sequencer state and working registers
	// ------------------------------------------------------------------
	dbrf_pkg::state_t state_q, state_nx;
	dbrf_pkg::cmd_t   cmd_q;
	logic [AW-1:0]    init_q;
	logic [CW-1:0]    xs_q, xe_q, col_q;
	logic [RW-1:0]    ys_q, ye_q, row_q;
	logic [AW-1:0]    rowbase_q;
	logic             go_q;
	logic             drew_q;
	logic [31:0]      pix_q;
	logic [31:0]      draw_cnt_q;
	logic [31:0]      flip_cnt_q;
	logic             rsp_valid_q;
	dbrf_pkg::rsp_t   rsp_q;

	logic cmd_take;
	logic rsp_free;
	logic init_last;
	logic walk_last;
	logic col_last;

	assign cmd_take  = cmd_valid & ~cmd_stall;
	assign rsp_free  = ~rsp_valid_q | ~rsp_stall;
	assign init_last = (init_q == AW'(DEPTH - 1));
	assign col_last  = ((col_q + CW'(1)) == xe_q);
	assign walk_last = col_last & ((row_q + RW'(1)) == ye_q);

	// ------------------------------------------------------------------
	// Clip unit: map every command onto a rectangle and clip it
	// ------------------------------------------------------------------
	logic signed [GW-1:0] gx, gy, gw, gh, bx, by;
	logic signed [GW-1:0] xs, xe, ys, ye, xe_raw, ye_raw;
	logic                 hit, go, drew;

	always_comb begin
		by = GW'(h_sat);
		case (cmd_q.action)
			dbrf_pkg::ACT_CLEAR: begin
				gx = '0;
				gy = '0;
				gw = GW'(s_sat);
				gh = GW'(h_sat);
				bx = GW'(s_sat);
			end
			dbrf_pkg::ACT_FLIP: begin
				gx = '0;
				gy = '0;
				gw = GW'(w_sat);
				gh = GW'(h_sat);
				bx = GW'(w_sat);
			end
			dbrf_pkg::ACT_FILL: begin
				gx = GW'(cmd_q.pos_x);
				gy = GW'(cmd_q.pos_y);
				gw = GW'(cmd_q.rect_w);
				gh = GW'(cmd_q.rect_h);
				bx = GW'(w_sat);
			end
			dbrf_pkg::ACT_PUT, dbrf_pkg::ACT_READ: begin
				gx = GW'(cmd_q.pos_x);
				gy = GW'(cmd_q.pos_y);
				gw = GW'(1);
				gh = GW'(1);
				bx = GW'(w_sat);
			end
			default: begin
				gx = '0;
				gy = '0;
				gw = '0;
				gh = '0;
				bx = GW'(w_sat);
			end
		endcase

		xe_raw = gx + gw;
		ye_raw = gy + gh;
		xs     = (gx < 0) ? '0 : gx;
		ys     = (gy < 0) ? '0 : gy;
		xe     = (xe_raw > bx) ? bx : xe_raw;
		ye     = (ye_raw > by) ? by : ye_raw;
		hit    = (xe > xs) && (ye > ys);

		go = hit && ((cmd_q.action == dbrf_pkg::ACT_READ) ||
			(enable_q && ((cmd_q.action == dbrf_pkg::ACT_CLEAR) ||
			(cmd_q.action == dbrf_pkg::ACT_PUT) ||
			(cmd_q.action == dbrf_pkg::ACT_FILL) ||
			(cmd_q.action == dbrf_pkg::ACT_FLIP))));

		drew = enable_q && ((cmd_q.action == dbrf_pkg::ACT_CLEAR) ||
			(cmd_q.action == dbrf_pkg::ACT_FLIP) ||
			(hit && ((cmd_q.action == dbrf_pkg::ACT_PUT) ||
			(cmd_q.action == dbrf_pkg::ACT_FILL))));
	end

	// Row base multiply
	logic [RW+CW-1:0] prod;
	assign prod = (RW+CW)'(ys_q) * (RW+CW)'(s_sat);

	// Walk address: row base plus column
	logic [AW-1:0] walk_addr;
	assign walk_addr = rowbase_q + AW'(col_q);

	// ------------------------------------------------------------------
	// Next state
	// ------------------------------------------------------------------
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			dbrf_pkg::ST_INIT:  if (init_last) state_nx = dbrf_pkg::ST_IDLE;
			dbrf_pkg::ST_IDLE:  if (cmd_take) state_nx = dbrf_pkg::ST_SETUP;
			dbrf_pkg::ST_SETUP: state_nx = go ? dbrf_pkg::ST_MUL : dbrf_pkg::ST_DRAIN;
			dbrf_pkg::ST_MUL:   state_nx = dbrf_pkg::ST_WALK;
			dbrf_pkg::ST_WALK:  if (walk_last) state_nx = dbrf_pkg::ST_DRAIN;
			dbrf_pkg::ST_DRAIN: state_nx = dbrf_pkg::ST_DONE;
			dbrf_pkg::ST_DONE:  if (rsp_free) state_nx = dbrf_pkg::ST_IDLE;
			default:            state_nx = dbrf_pkg::ST_INIT;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer outputs: store port controls
	// ------------------------------------------------------------------
	logic          back_we;
	logic [AW-1:0] back_waddr;
	logic [31:0]   back_wdata;
	logic          front_we;
	logic [AW-1:0] front_waddr;
	logic [31:0]   front_wdata;
	logic          flip_rd;
	logic          flip_we_s1;
	logic [AW-1:0] flip_addr_s1;
	logic [31:0]   back_rd_q;
	logic [31:0]   front_rd_q;

	always_comb begin
		cmd_stall   = (state_q != dbrf_pkg::ST_IDLE);
		back_we     = 1'b0;
		back_waddr  = walk_addr;
		back_wdata  = cmd_q.color;
		front_we    = flip_we_s1;
		front_waddr = flip_addr_s1;
		front_wdata = back_rd_q;
		flip_rd     = 1'b0;
		unique case (state_q)
			dbrf_pkg::ST_INIT: begin
				back_we     = 1'b1;
				back_waddr  = init_q;
				back_wdata  = '0;
				front_we    = 1'b1;
				front_waddr = init_q;
				front_wdata = '0;
			end
			dbrf_pkg::ST_WALK: begin
				back_we = (cmd_q.action == dbrf_pkg::ACT_CLEAR) ||
					(cmd_q.action == dbrf_pkg::ACT_PUT) ||
					(cmd_q.action == dbrf_pkg::ACT_FILL);
				flip_rd = (cmd_q.action == dbrf_pkg::ACT_FLIP);
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Pixel stores
	// ------------------------------------------------------------------
	logic [31:0] back_mem  [DEPTH];
	logic [31:0] front_mem [DEPTH];

	// Back store: one write port, registered read at the walk address
	always_ff @(posedge clk) begin
		if (back_we) begin
			back_mem[back_waddr] <= back_wdata;
		end
		back_rd_q <= back_mem[walk_addr];
	end

	// Front store: written by the sweep or the delayed flip copy
	always_ff @(posedge clk) begin
		if (front_we) begin
			front_mem[front_waddr] <= front_wdata;
		end
		front_rd_q <= front_mem[walk_addr];
	end

	// Delay the flip write by the back store read latency
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flip_we_s1 <= 1'b0;
		end else begin
			flip_we_s1 <= flip_rd;
		end
	end

	always_ff @(posedge clk) begin
		flip_addr_s1 <= walk_addr;
	end

	// ------------------------------------------------------------------
	// Sequencer registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= dbrf_pkg::ST_INIT;
			init_q     <= '0;
			draw_cnt_q <= '0;
			flip_cnt_q <= '0;
			go_q       <= 1'b0;
			drew_q     <= 1'b0;
		end else begin
			state_q <= state_nx;
			// advance the clearing sweep
			if (state_q == dbrf_pkg::ST_INIT) begin
				init_q <= init_q + AW'(1);
			end
			// latch clip decisions
			if (state_q == dbrf_pkg::ST_SETUP) begin
				go_q   <= go;
				drew_q <= drew;
			end
			// bump the counters once the store work has drained
			if (state_q == dbrf_pkg::ST_DRAIN && drew_q) begin
				if (cmd_q.action == dbrf_pkg::ACT_FLIP) begin
					flip_cnt_q <= flip_cnt_q + 32'd1;
				end else begin
					draw_cnt_q <= draw_cnt_q + 32'd1;
				end
			end
		end
	end

	// Payload and walk registers
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cmd_q <= cmd;
		end
		if (state_q == dbrf_pkg::ST_SETUP) begin
			xs_q <= xs[CW-1:0];
			xe_q <= xe[CW-1:0];
			ys_q <= ys[RW-1:0];
			ye_q <= ye[RW-1:0];
		end
		if (state_q == dbrf_pkg::ST_MUL) begin
			rowbase_q <= prod[AW-1:0];
			col_q     <= xs_q;
			row_q     <= ys_q;
		end
		// step column, wrap to the next row at the right edge
		if (state_q == dbrf_pkg::ST_WALK) begin
			if (col_last) begin
				col_q     <= xs_q;
				row_q     <= row_q + RW'(1);
				rowbase_q <= rowbase_q + AW'(s_sat);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
		// capture the front pixel for a read
		if (state_q == dbrf_pkg::ST_DRAIN) begin
			pix_q <= (go_q && cmd_q.action == dbrf_pkg::ACT_READ) ? front_rd_q : '0;
		end
	end

	// ------------------------------------------------------------------
	// Response register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == dbrf_pkg::ST_DONE && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (~rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == dbrf_pkg::ST_DONE && rsp_free) begin
			rsp_q.front_pixel <= pix_q;
			rsp_q.drew        <= drew_q;
			rsp_q.draw_total  <= draw_cnt_q;
			rsp_q.flip_total  <= flip_cnt_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
`ifndef SYNTHESIS
	// walker stays inside the clipped rectangle
	a_walk_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dbrf_pkg::ST_WALK |-> (col_q < xe_q) && (row_q < ye_q))
		else $error("walker left the clipped rectangle");

	// walk address never runs past the store depth
	a_walk_addr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dbrf_pkg::ST_WALK |-> {1'b0, walk_addr} < (AW+1)'(DEPTH))
		else $error("walk address beyond store depth");

	// a counted flip bumps the flip counter by exactly one
	a_flip_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dbrf_pkg::ST_DRAIN && drew_q && cmd_q.action == dbrf_pkg::ACT_FLIP
		|=> flip_cnt_q == $past(flip_cnt_q) + 32'd1)
		else $error("flip counter did not advance");

	// a drawing response never carries a front pixel
	a_drew_no_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.drew |-> rsp.front_pixel == 32'd0)
		else $error("drawing response carries a pixel");

	// no command is taken during the clearing sweep
	a_init_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dbrf_pkg::ST_INIT |=> !$past(cmd_take))
		else $error("command taken during clearing sweep");
`endif

endmodule

// ----- tb/sv/rect_fill_checker.sv -----
`timescale 1ns / 1ps
// Response checker for the double-buffered rectangle fill engine: tracks the register
// port, predicts every response beat from the accepted commands and compares it.
// Depends on src/dbrf_pkg.sv.
module rect_fill_checker
	import dbrf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  logic        cmd_stall,
	input  cmd_t        cmd,
	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  rsp_t        rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          error_count,
	output int          responses_owed
);

	localparam int STORE_WORDS = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;

	// Shadow copies of both pixel stores and the counters
	bit [31:0]  back_pixels  [STORE_WORDS];
	bit [31:0]  front_pixels [STORE_WORDS];
	bit [31:0]  draw_count = '0;
	bit [31:0]  swap_count = '0;

	// Shadow copies of the registers, at their reset values
	logic       eng_on    = 1'b0;
	logic [8:0] scr_w     = 9'd256;
	logic [8:0] scr_h     = 9'd256;
	logic [8:0] row_pitch = 9'd256;

	rsp_t       pending_responses [$];
	int         beat_index;

	initial begin
		error_count    = 0;
		responses_owed = 0;
		beat_index     = 0;
	end

	function automatic int clamp_dim(logic [8:0] v, int cap);
		return (int'(v) > cap) ? cap : int'(v);
	endfunction

	function automatic int store_addr(int row, int col, int pitch);
		return (row * pitch + col) % STORE_WORDS;
	endfunction

	// Apply one command to the shadow state and return the response it yields
	function automatic rsp_t render_command(cmd_t c);
		rsp_t o;
		int   x, y, w, h, wv, hv, sv, n;
		o  = '0;
		x  = int'(c.pos_x);
		y  = int'(c.pos_y);
		w  = int'(c.rect_w);
		h  = int'(c.rect_h);
		wv = clamp_dim(scr_w, MAX_WIDTH_DEF);
		hv = clamp_dim(scr_h, MAX_HEIGHT_DEF);
		sv = clamp_dim(row_pitch, MAX_WIDTH_DEF);
		if (c.action == ACT_READ) begin
			// the scan-out port works even when the engine is off
			if (x >= 0 && y >= 0 && x < wv && y < hv)
				o.front_pixel = front_pixels[store_addr(y, x, sv)];
		end else if (eng_on && c.action == ACT_CLEAR) begin
			n = (sv * hv > STORE_WORDS) ? STORE_WORDS : sv * hv;
			for (int i = 0; i < n; i++)
				back_pixels[i] = c.color;
			draw_count++;
			o.drew = 1'b1;
		end else if (eng_on && c.action == ACT_PUT) begin
			if (x >= 0 && y >= 0 && x < wv && y < hv) begin
				back_pixels[store_addr(y, x, sv)] = c.color;
				draw_count++;
				o.drew = 1'b1;
			end
		end else if (eng_on && c.action == ACT_FILL) begin
			// clip: a negative origin eats into the extent, then cut at the far edges
			if (x < 0) begin
				w = w + x;
				x = 0;
			end
			if (y < 0) begin
				h = h + y;
				y = 0;
			end
			if (x + w > wv)
				w = wv - x;
			if (y + h > hv)
				h = hv - y;
			if (w > 0 && h > 0) begin
				for (int r = 0; r < h; r++)
					for (int k = 0; k < w; k++)
						back_pixels[store_addr(y + r, x + k, sv)] = c.color;
				draw_count++;
				o.drew = 1'b1;
			end
		end else if (eng_on && c.action == ACT_FLIP) begin
			for (int r = 0; r < hv; r++)
				for (int k = 0; k < wv; k++)
					front_pixels[store_addr(r, k, sv)] = back_pixels[store_addr(r, k, sv)];
			swap_count++;
			o.drew = 1'b1;
		end
		o.draw_total = draw_count;
		o.flip_total = swap_count;
		return o;
	endfunction

	// Track register writes, retire response beats, then queue new predictions
	always @(posedge clk) begin
		rsp_t want;
		logic bad;
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_ENABLE: eng_on    = pwdata[0];
					REG_WIDTH:  scr_w     = pwdata[8:0];
					REG_HEIGHT: scr_h     = pwdata[8:0];
					REG_STRIDE: row_pitch = pwdata[8:0];
					default: ;
				endcase
			end
			if (rsp_valid && !rsp_stall) begin
				if (pending_responses.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display("%0t ns: response beat %0d arrived with no command waiting",
							$time, beat_index);
				end else begin
					want = pending_responses.pop_front();
					bad  = (rsp.front_pixel !== want.front_pixel) || (rsp.drew !== want.drew) ||
						(rsp.draw_total !== want.draw_total) ||
						(rsp.flip_total !== want.flip_total);
					if (bad) begin
						error_count++;
						if (error_count <= 10)
							$display({"%0t ns: response beat %0d mismatch: front_pixel exp %h got %h,",
								" drew exp %b got %b, draw_total exp %0d got %0d,",
								" flip_total exp %0d got %0d"},
								$time, beat_index, want.front_pixel, rsp.front_pixel,
								want.drew, rsp.drew, want.draw_total, rsp.draw_total,
								want.flip_total, rsp.flip_total);
					end
				end
				beat_index++;
			end
			if (cmd_valid && !cmd_stall)
				pending_responses.push_back(render_command(cmd));
			responses_owed <= pending_responses.size();
		end
	end

endmodule

// ----- tb/sv/tb_double_buffered_rect_fill_engine.sv -----
`timescale 1ns / 1ps
// Top-level testbench for the double-buffered rectangle fill engine: clock, reset,
// register programming, command stimulus and response back-pressure.
// Depends on src/dbrf_pkg.sv, src/double_buffered_rect_fill_engine.sv, rect_fill_checker.sv.
module tb_double_buffered_rect_fill_engine;
	import dbrf_pkg::*;

	localparam logic [2:0] ACT_CODE_MAX = '1;
	localparam int         HOLD_CYCLES  = 400;

	logic        clk;
	logic        arst_n;
	logic        cmd_valid;
	logic        cmd_stall;
	cmd_t        cmd;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_t        rsp;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int error_count;
	int responses_owed;

	// Pacing knobs, current screen spans for random geometry, long hold-off request
	int gap_pct   = 0;
	int stall_pct = 0;
	int cur_w     = MAX_WIDTH_DEF;
	int cur_h     = MAX_HEIGHT_DEF;
	int cur_ext   = 16;
	int hold_req  = 0;
	int hold_ack  = 0;
	int hold_left = 0;

	double_buffered_rect_fill_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	rect_fill_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd_stall      (cmd_stall),
		.cmd            (cmd),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.rsp            (rsp),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.pready         (pready),
		.error_count    (error_count),
		.responses_owed (responses_owed)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Stall the response channel at random, or hold it off for a long stretch on request
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack  <= hold_req;
			hold_left <= HOLD_CYCLES;
			rsp_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	function automatic cmd_t make_cmd(logic [2:0] act, int x, int y, int w, int h,
		logic [31:0] color);
		cmd_t c;
		c.action = act;
		c.pos_x  = 16'(x);
		c.pos_y  = 16'(y);
		c.rect_w = 16'(w);
		c.rect_h = 16'(h);
		c.color  = color;
		return c;
	endfunction

	// Mostly near the screen, sometimes at the edges or anywhere in 16 bits
	function automatic int pick_coord(int span);
		int edges [6];
		edges = '{-32768, 32767, -1, 0, span - 1, span};
		case ($urandom_range(9))
			0: return int'($signed(16'($urandom)));
			1: return edges[$urandom_range(5)];
			default: return int'($urandom_range(span + 7)) - 4;
		endcase
	endfunction

	// Keep extents within the larger screen span unless heavy commands are allowed, so fills stay cheap
	function automatic int pick_extent(int ext_max, bit heavy_ok);
		int edges [5];
		edges = '{-32768, -1, 0, 1, heavy_ok ? 32767 : ext_max};
		case ($urandom_range(9))
			0: return heavy_ok ? int'($signed(16'($urandom))) : -int'($urandom_range(32768, 1));
			1: return edges[$urandom_range(4)];
			default: return int'($urandom_range(ext_max + 3)) - 3;
		endcase
	endfunction

	function automatic cmd_t random_command(bit heavy_ok);
		int         pick;
		logic [2:0] act;
		pick = $urandom_range(99);
		if (pick < 6)
			act = heavy_ok ? ACT_CLEAR : ACT_PUT;
		else if (pick < 36)
			act = ACT_PUT;
		else if (pick < 66)
			act = ACT_FILL;
		else if (pick < 72)
			act = heavy_ok ? ACT_FLIP : ACT_READ;
		else if (pick < 96)
			act = ACT_READ;
		else
			act = 3'($urandom_range(ACT_CODE_MAX, int'(ACT_READ) + 1));
		return make_cmd(act, pick_coord(cur_w), pick_coord(cur_h),
			pick_extent(cur_ext, heavy_ok), pick_extent(cur_ext, heavy_ok), $urandom);
	endfunction

	// Offer one beat after a random gap and hold it until accepted
	task automatic push_command(cmd_t c);
		while ($urandom_range(99) < gap_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
	endtask

	task automatic send_random(int count, bit heavy_ok);
		repeat (count)
			push_command(random_command(heavy_ok));
	endtask

	// Drop valid and wait until every predicted response has come back
	task automatic settle_engine();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (responses_owed != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Setup and access phase; back-to-back writes keep psel high
	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
	endtask

	task automatic configure_scene(logic [31:0] en_word, int w, int h, int s, int pacing);
		settle_engine();
		write_reg(REG_ENABLE, en_word);
		write_reg(REG_WIDTH, 32'(w));
		write_reg(REG_HEIGHT, 32'(h));
		write_reg(REG_STRIDE, 32'(s));
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (pacing)
			0: begin
				gap_pct   = 0;
				stall_pct = 0;
			end
			1: begin
				gap_pct   = 47;
				stall_pct = 0;
			end
			2: begin
				gap_pct   = 0;
				stall_pct = 47;
			end
			default: begin
				gap_pct   = 36;
				stall_pct = 36;
			end
		endcase
		cur_w   = (w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w;
		cur_h   = (h > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : h;
		cur_ext = (cur_w > cur_h) ? cur_w : cur_h;
	endtask

	initial begin
		arst_n    <= 1'b0;
		cmd_valid <= 1'b0;
		cmd       <= '0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Engine still off at reset geometry: only the read port does anything
		push_command(make_cmd(ACT_CLEAR, 0, 0, 0, 0, 32'hFFFF_FFFF));
		push_command(make_cmd(ACT_PUT, 0, 0, 0, 0, 32'hDEAD_BEEF));
		push_command(make_cmd(ACT_FILL, 0, 0, 256, 256, 32'h1234_5678));
		push_command(make_cmd(ACT_FLIP, 0, 0, 0, 0, 32'h0));
		push_command(make_cmd(ACT_READ, 255, 255, 0, 0, 32'h0));
		push_command(make_cmd(ACT_CODE_MAX, -32768, 32767, -32768, 32767, 32'hFFFF_FFFF));

		// Small screen: edges of put and fill, clipping, flip, reads in and out of range
		configure_scene(32'd1, 16, 16, 16, 0);
		push_command(make_cmd(ACT_CLEAR, 0, 0, 0, 0, 32'hA5A5_A5A5));
		push_command(make_cmd(ACT_PUT, 0, 0, 0, 0, 32'hFFFF_FFFF));
		push_command(make_cmd(ACT_PUT, 15, 15, 0, 0, 32'h0000_0001));
		push_command(make_cmd(ACT_PUT, 16, 3, 0, 0, 32'h5555_5555));
		push_command(make_cmd(ACT_PUT, -1, 0, 0, 0, 32'h6666_6666));
		push_command(make_cmd(ACT_PUT, 32767, -32768, 0, 0, 32'h7777_7777));
		push_command(make_cmd(ACT_FILL, -4, -4, 10, 10, 32'h1111_1111));
		push_command(make_cmd(ACT_FILL, 10, 10, 32767, 32767, 32'h2222_2222));
		push_command(make_cmd(ACT_FILL, 3, 3, -5, 4, 32'h3333_3333));
		push_command(make_cmd(ACT_FILL, -32768, -32768, 32767, 32767, 32'h4444_4444));
		push_command(make_cmd(ACT_FILL, 0, 0, 0, 5, 32'h8888_8888));
		push_command(make_cmd(ACT_FLIP, 0, 0, 0, 0, 32'h0));
		push_command(make_cmd(ACT_READ, 0, 0, 0, 0, 32'h0));
		push_command(make_cmd(ACT_READ, 15, 15, 0, 0, 32'h0));
		push_command(make_cmd(ACT_READ, 16, 0, 0, 0, 32'h0));
		push_command(make_cmd(ACT_READ, -1, -1, 0, 0, 32'h0));
		push_command(make_cmd(ACT_CODE_MAX - 3'd1, 2, 2, 2, 2, 32'h9999_9999));

		// Random traffic, then a long response hold-off while commands keep coming
		send_random(50, 1'b1);
		hold_req++;
		send_random(30, 1'b0);
		settle_engine();
		send_random(50, 1'b1);

		configure_scene(32'd1, 1, 1, 1, 1);
		send_random(50, 1'b1);

		// Full-size screen: one big clear and flip, otherwise random commands with no clear or flip
		configure_scene(32'd1, 256, 256, 256, 2);
		push_command(make_cmd(ACT_CLEAR, 0, 0, 0, 0, $urandom));
		send_random(30, 1'b0);
		push_command(make_cmd(ACT_FLIP, 0, 0, 0, 0, 32'h0));
		send_random(10, 1'b0);

		// Stride wider than the screen, then narrower
		configure_scene(32'd1, 40, 20, 64, 3);
		send_random(120, 1'b1);
		configure_scene(32'd1, 32, 8, 5, 0);
		send_random(80, 1'b1);

		// Oversized width saturates, zero stride aliases every row onto row 0
		configure_scene(32'd1, 300, 4, 0, 1);
		send_random(50, 1'b1);
		// No rows on screen; then no columns
		configure_scene(32'd1, 20, 0, 511, 2);
		send_random(30, 1'b1);
		configure_scene(32'd1, 0, 12, 20, 3);
		send_random(30, 1'b1);

		// Disable with junk in the upper bits, then enable again the same way
		configure_scene(32'hFFFF_FFFE, 24, 24, 24, 3);
		send_random(40, 1'b1);
		configure_scene(32'hFFFF_FFFF, 24, 24, 24, 0);
		send_random(40, 1'b1);

		settle_engine();
		repeat (24) @(posedge clk);
		if (error_count == 0 && responses_owed == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Watchdog: end the run if the engine hangs
	initial begin
		#64_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
